// ----- rtl/core/eppm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the projection matrix unit.
package eppm_pkg;

  localparam int MAX_LEVELS   = 8;
  localparam int LVL_MAX      = MAX_LEVELS - 1;
  localparam int ITEM_CYCLES  = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW_TERM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PYRAMID_LEVEL = 3'd5;

  // angle reduction, 1/128 degree units
  localparam logic [16:0] FULL_TURN    = 17'd46080;
  localparam logic [15:0] QUARTER_TURN = 16'd11520;
  // pi in Q30 split as PI_A * 23040 + PI_B
  localparam logic [17:0] PI_A     = 18'd146408;
  localparam logic [14:0] PI_B     = 15'd19106;
  localparam logic [27:0] HALF_DIV = 28'd11520;
  localparam logic [18:0] DIV45    = 19'd45;
  localparam logic [18:0] REC45    = 19'd372827;   // floor(2^24 / 45)

  localparam logic [30:0] ONE_Q30  = 31'd1073741824;
  localparam int SIN_TERMS = 6;
  localparam int COS_TERMS = 7;
  localparam int STEP_LAT  = 4;
  localparam int FRONT_LAT = 8;
  localparam int SC_LAT    = FRONT_LAT + COS_TERMS * STEP_LAT + 1;
  localparam int TR_LAT    = SC_LAT + 3;
  localparam int PIPE_LAT  = SC_LAT + 7;

  localparam logic signed [49:0] SAT_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] SAT_MIN = -50'sd140737488355328;

  typedef struct packed {
    logic signed [15:0] angle_a;
    logic signed [15:0] angle_b;
    logic signed [15:0] angle_g;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } pose_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [47:0] entry0;
    logic signed [47:0] entry1;
    logic signed [47:0] entry2;
    logic signed [47:0] entry3;
    logic               last_row;
  } row_t;

  // Taylor divisors of the Horner chains and their 2^32 reciprocals
  function automatic logic [7:0] sin_div(input int i);
    case (i)
      0: return 8'd156;
      1: return 8'd110;
      2: return 8'd72;
      3: return 8'd42;
      4: return 8'd20;
      default: return 8'd6;
    endcase
  endfunction

  function automatic logic [31:0] sin_recip(input int i);
    case (i)
      0: return 32'd27531841;
      1: return 32'd39045157;
      2: return 32'd59652323;
      3: return 32'd102261126;
      4: return 32'd214748364;
      default: return 32'd715827882;
    endcase
  endfunction

  function automatic logic [7:0] cos_div(input int i);
    case (i)
      0: return 8'd182;
      1: return 8'd132;
      2: return 8'd90;
      3: return 8'd56;
      4: return 8'd30;
      5: return 8'd12;
      default: return 8'd2;
    endcase
  endfunction

  function automatic logic [31:0] cos_recip(input int i);
    case (i)
      0: return 32'd23598721;
      1: return 32'd32537631;
      2: return 32'd47721858;
      3: return 32'd76695844;
      4: return 32'd143165576;
      5: return 32'd357913941;
      default: return 32'd2147483648;
    endcase
  endfunction

  // Q30 product, rounded half up
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'((p + 64'sd536870912) >>> 30);
  endfunction

  // right shift by s with rounding half up
  function automatic logic signed [49:0] round_lvl(input logic signed [49:0] v,
                                                   input logic [2:0] s);
    logic signed [49:0] bias;
    bias = (s == 3'd0) ? 50'sd0 : (50'sd1 <<< (s - 3'd1));
    return (v + bias) >>> s;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [49:0] c;
    c = (v > SAT_MAX) ? SAT_MAX : ((v < SAT_MIN) ? SAT_MIN : v);
    return c[47:0];
  endfunction

endpackage

// ----- rtl/core/eppm_horner_step.sv -----
// One Horner step t' = 1 - x2*t/d in Q30, four register stages.
module eppm_horner_step (
  input  logic        clk,
  input  logic [31:0] x2_in,
  input  logic [30:0] t_in,
  input  logic [7:0]  div,
  input  logic [31:0] recip,
  output logic [31:0] x2_out,
  output logic [30:0] t_out
);
  import eppm_pkg::*;

  logic [62:0] p;
  logic [31:0] q2;
  logic [31:0] q3;
  logic [63:0] qm;
  logic [31:0] x2_s1, x2_s2, x2_s3;
  logic [34:0] q_sum;
  logic [31:0] est;
  logic [39:0] rem;
  logic [31:0] sub;

  // rounding folded in: floor((p + d*2^29) / 2^30) = (p>>29 + d) >> 1
  assign q_sum = {1'b0, p[62:29]} + 35'(div);
  assign est   = qm[63:32];
  assign rem   = 40'(q3) - 40'(est) * 40'(div);
  assign sub   = est + 32'(rem >= 40'(div));

  always_ff @(posedge clk) begin
    p      <= 63'(x2_in) * 63'(t_in);
    x2_s1  <= x2_in;
    q2     <= q_sum[32:1];
    x2_s2  <= x2_s1;
    qm     <= 64'(q2) * 64'(recip);
    q3     <= q2;
    x2_s3  <= x2_s2;
    t_out  <= (sub > 32'(ONE_Q30)) ? 31'd0 : 31'(32'(ONE_Q30) - sub);
    x2_out <= x2_s3;
  end

endmodule

// ----- rtl/core/eppm_sincos.sv -----
// Pipelined sine and cosine of an angle in 1/128 degree, Q2.30 results.
module eppm_sincos (
  input  logic               clk,
  input  logic signed [15:0] angle,
  output logic signed [31:0] sin_out,
  output logic signed [31:0] cos_out
);
  import eppm_pkg::*;

  localparam int X_DLY    = SIN_TERMS * STEP_LAT;
  localparam int QUAD_DLY = COS_TERMS * STEP_LAT;

  logic [15:0] r_a;
  logic [1:0]  quad_b, quad_c, quad_d, quad_e, quad_f, quad_g, quad_h;
  logic [13:0] f_b;
  logic [30:0] fa_c, fa_d, fa_e;
  logic [27:0] y_c;
  logic [37:0] q2m_d;
  logic [18:0] q2_d;
  logic [13:0] e45_e;
  logic [6:0]  r45_e;
  logic [30:0] x_f, x_g, x_h;
  logic [61:0] xx_g;
  logic [31:0] x2_h;
  logic [16:0] r_sum;
  logic [18:0] r45_full;

  logic [31:0] sx2 [0:SIN_TERMS];
  logic [30:0] st  [0:SIN_TERMS];
  logic [31:0] cx2 [0:COS_TERMS];
  logic [30:0] ct  [0:COS_TERMS];
  logic [30:0] x_dly    [0:X_DLY-1];
  logic [1:0]  quad_dly [0:QUAD_DLY-1];
  logic [61:0] sprod;
  logic [30:0] sv, sv_d1, sv_d2;
  logic signed [31:0] sv_s, cv_s;

  assign r_sum    = 17'(angle) + FULL_TURN;
  assign r45_full = q2_d - 19'(q2m_d[37:24]) * DIV45;

  always_ff @(posedge clk) begin
    r_a <= angle[15] ? r_sum[15:0] : angle[15:0];
    if (r_a >= 16'(QUARTER_TURN * 3)) begin
      quad_b <= 2'd3;
      f_b    <= 14'(r_a - 16'(QUARTER_TURN * 3));
    end else if (r_a >= 16'(QUARTER_TURN * 2)) begin
      quad_b <= 2'd2;
      f_b    <= 14'(r_a - 16'(QUARTER_TURN * 2));
    end else if (r_a >= QUARTER_TURN) begin
      quad_b <= 2'd1;
      f_b    <= 14'(r_a - QUARTER_TURN);
    end else begin
      quad_b <= 2'd0;
      f_b    <= r_a[13:0];
    end
    fa_c   <= 31'(f_b) * 31'(PI_A);
    y_c    <= 28'(f_b) * 28'(PI_B) + HALF_DIV;
    quad_c <= quad_b;
    q2_d   <= y_c[27:9];
    q2m_d  <= 38'(y_c[27:9]) * 38'(REC45);
    fa_d   <= fa_c;
    quad_d <= quad_c;
    e45_e  <= q2m_d[37:24];
    r45_e  <= r45_full[6:0];
    fa_e   <= fa_d;
    quad_e <= quad_d;
    x_f    <= fa_e + 31'(e45_e) + 31'(r45_e >= 7'(DIV45));
    quad_f <= quad_e;
    xx_g   <= 62'(x_f) * 62'(x_f);
    x_g    <= x_f;
    quad_g <= quad_f;
    x2_h   <= 32'((xx_g + 62'd536870912) >> 30);
    x_h    <= x_g;
    quad_h <= quad_g;
  end

  assign sx2[0] = x2_h;
  assign st[0]  = ONE_Q30;
  assign cx2[0] = x2_h;
  assign ct[0]  = ONE_Q30;

  for (genvar g = 0; g < SIN_TERMS; g++) begin : g_sin
    eppm_horner_step u_step (
      .clk    (clk),
      .x2_in  (sx2[g]),
      .t_in   (st[g]),
      .div    (sin_div(g)),
      .recip  (sin_recip(g)),
      .x2_out (sx2[g+1]),
      .t_out  (st[g+1])
    );
  end

  for (genvar g = 0; g < COS_TERMS; g++) begin : g_cos
    eppm_horner_step u_step (
      .clk    (clk),
      .x2_in  (cx2[g]),
      .t_in   (ct[g]),
      .div    (cos_div(g)),
      .recip  (cos_recip(g)),
      .x2_out (cx2[g+1]),
      .t_out  (ct[g+1])
    );
  end

  always_ff @(posedge clk) begin
    x_dly[0]    <= x_h;
    quad_dly[0] <= quad_h;
    for (int i = 1; i < X_DLY; i++) x_dly[i] <= x_dly[i-1];
    for (int i = 1; i < QUAD_DLY; i++) quad_dly[i] <= quad_dly[i-1];
    // sin = x * series, then align with the longer cosine chain
    sprod <= 62'(x_dly[X_DLY-1]) * 62'(st[SIN_TERMS]);
    sv    <= 31'((sprod + 62'd536870912) >> 30);
    sv_d1 <= sv;
    sv_d2 <= sv_d1;
  end

  assign sv_s = $signed({1'b0, sv_d2});
  assign cv_s = $signed({1'b0, ct[COS_TERMS]});

  always_ff @(posedge clk) begin
    case (quad_dly[QUAD_DLY-1])
      2'd0: begin
        sin_out <= sv_s;
        cos_out <= cv_s;
      end
      2'd1: begin
        sin_out <= cv_s;
        cos_out <= -sv_s;
      end
      2'd2: begin
        sin_out <= -sv_s;
        cos_out <= -cv_s;
      end
      default: begin
        sin_out <= -cv_s;
        cos_out <= sv_s;
      end
    endcase
  end

endmodule

// ----- rtl/core/euler_pose_projection_matrix_unit.sv -----
// Top level: camera pose in, three rows of the 3x4 projection matrix out.
//
// Use:
//   A pose beat is taken at a rising edge with start high and busy low. busy
//   then rises and holds off further poses until busy_cnt runs down; three
//   result beats leave per pose on one strobe channel.
//   Results appear on row for one cycle each with row_strobe high: row 0,
//   row 1, row 2 in consecutive cycles, last_row set on row 2. The receiver
//   has no way to hold results off, and the block never needs it to.
//   Path: row 0 passes 45 register stages from the accepting edge, counting
//   the one at that edge: 37 in the sine/cosine pipeline, 3 forming R, 4
//   applying K and the level shift, 1 in the output register.
//   Intake: a new pose may be taken while earlier ones are in flight; the
//   spacing is set by the single result channel with three rows per pose.
//   Config: cfg_we writes cfg_data into register cfg_index (0 focal_x,
//   1 focal_y, 2 skew_term, 3 center_x, 4 center_y, 5 pyramid_level);
//   other indexes are dropped. Write only while no pose is in flight.
//   Reset (rst, synchronous): registers return to focal 1.0, skew and
//   center 0, level 0; in-flight poses are dropped and no beat follows.
module euler_pose_projection_matrix_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  eppm_pkg::pose_t                        pose,
  input  logic                                   cfg_we,
  input  logic [eppm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [eppm_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   row_strobe,
  output eppm_pkg::row_t                         row
);
  import eppm_pkg::*;

  // ---- configuration registers ----
  logic [30:0]        focal_x, focal_y, center_x, center_y;
  logic signed [31:0] skew_term;
  logic [2:0]         pyramid_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x       <= 31'd65536;
      focal_y       <= 31'd65536;
      skew_term     <= 32'sd0;
      center_x      <= 31'd0;
      center_y      <= 31'd0;
      pyramid_level <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_X:       focal_x       <= cfg_data[30:0];
        REG_FOCAL_Y:       focal_y       <= cfg_data[30:0];
        REG_SKEW_TERM:     skew_term     <= $signed(cfg_data);
        REG_CENTER_X:      center_x      <= cfg_data[30:0];
        REG_CENTER_Y:      center_y      <= cfg_data[30:0];
        REG_PYRAMID_LEVEL: pyramid_level <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // ---- intake: accept gated by busy ----
  logic       accept;
  logic [1:0] busy_cnt;

  assign accept = start & ~busy;
  assign busy   = (busy_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cnt <= 2'd0;
    end else if (accept) begin
      busy_cnt <= 2'(ITEM_CYCLES - 1);
    end else if (busy_cnt != 2'd0) begin
      busy_cnt <= busy_cnt - 2'd1;
    end
  end

  // valid tags ride alongside the data; payload regs are not reset
  logic [PIPE_LAT-1:0] vld;
  pose_t               pose_dly [0:TR_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    pose_dly[0] <= pose;
    for (int i = 1; i < TR_LAT; i++) pose_dly[i] <= pose_dly[i-1];
  end

  // ---- sine and cosine of the three angles ----
  logic signed [31:0] s1, c1, s2, c2, s3, c3;

  eppm_sincos u_sc_a (.clk(clk), .angle(pose.angle_a), .sin_out(s1), .cos_out(c1));
  eppm_sincos u_sc_b (.clk(clk), .angle(pose.angle_b), .sin_out(s2), .cos_out(c2));
  eppm_sincos u_sc_g (.clk(clk), .angle(pose.angle_g), .sin_out(s3), .cos_out(c3));

  // ---- R = Rz * Ry * Rx ----
  // R1: pair products; R2: triple products; R3: sums
  logic signed [31:0] c3s2, s3s2, p_c2c3, p_s3c1, p_s3s1, p_s3c2;
  logic signed [31:0] p_c3c1, p_c3s1, p_c2s1, p_c2c1, s1_r, c1_r, s2_r;
  logic signed [31:0] t_c3s2s1, t_c3s2c1, t_s3s2s1, t_s3s2c1;
  logic signed [31:0] q_c2c3, q_s3c1, q_s3s1, q_s3c2, q_c3c1, q_c3s1, q_c2s1, q_c2c1;
  logic signed [31:0] s2_q;
  logic signed [32:0] rot [0:2][0:2];

  always_ff @(posedge clk) begin
    c3s2   <= mul30(c3, s2);
    s3s2   <= mul30(s3, s2);
    p_c2c3 <= mul30(c2, c3);
    p_s3c1 <= mul30(s3, c1);
    p_s3s1 <= mul30(s3, s1);
    p_s3c2 <= mul30(s3, c2);
    p_c3c1 <= mul30(c3, c1);
    p_c3s1 <= mul30(c3, s1);
    p_c2s1 <= mul30(c2, s1);
    p_c2c1 <= mul30(c2, c1);
    s1_r   <= s1;
    c1_r   <= c1;
    s2_r   <= s2;

    t_c3s2s1 <= mul30(c3s2, s1_r);
    t_c3s2c1 <= mul30(c3s2, c1_r);
    t_s3s2s1 <= mul30(s3s2, s1_r);
    t_s3s2c1 <= mul30(s3s2, c1_r);
    q_c2c3   <= p_c2c3;
    q_s3c1   <= p_s3c1;
    q_s3s1   <= p_s3s1;
    q_s3c2   <= p_s3c2;
    q_c3c1   <= p_c3c1;
    q_c3s1   <= p_c3s1;
    q_c2s1   <= p_c2s1;
    q_c2c1   <= p_c2c1;
    s2_q     <= s2_r;

    rot[0][0] <= 33'(q_c2c3);
    rot[0][1] <= 33'(t_c3s2s1) - 33'(q_s3c1);
    rot[0][2] <= 33'(t_c3s2c1) + 33'(q_s3s1);
    rot[1][0] <= 33'(q_s3c2);
    rot[1][1] <= 33'(t_s3s2s1) + 33'(q_c3c1);
    rot[1][2] <= 33'(t_s3s2c1) - 33'(q_c3s1);
    rot[2][0] <= -33'(s2_q);
    rot[2][1] <= 33'(q_c2s1);
    rot[2][2] <= 33'(q_c2c1);
  end

  // ---- P = K * [R | t] ----
  // K1: products; K2: rounding to Q16; K3: sums; K4: level shift, saturate
  logic signed [31:0] fx_s, fy_s, cx_s, cy_s;
  logic signed [64:0] kp_fx [0:2], kp_sk [0:2], kp_cx [0:2], kp_fy [0:2], kp_cy [0:2];
  logic signed [63:0] kt_fx, kt_sk, kt_cx, kt_fy, kt_cy;
  logic signed [49:0] r2_k1 [0:2], r2_k2 [0:2], r2_k3 [0:2];
  logic signed [31:0] tz_k1, tz_k2, tz_k3;
  logic signed [49:0] kr_fx [0:3], kr_sk [0:3], kr_cx [0:3], kr_fy [0:3], kr_cy [0:3];
  logic signed [49:0] row0 [0:3], row1 [0:3];
  logic [2:0]         lvl;
  row_t               mat0, mat1, mat2;
  pose_t              tr;

  assign fx_s = $signed({1'b0, focal_x});
  assign fy_s = $signed({1'b0, focal_y});
  assign cx_s = $signed({1'b0, center_x});
  assign cy_s = $signed({1'b0, center_y});
  assign tr   = pose_dly[TR_LAT-1];
  assign lvl  = (pyramid_level > 3'(LVL_MAX)) ? 3'(LVL_MAX) : pyramid_level;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      kp_fx[j] <= 65'(fx_s) * 65'(rot[0][j]);
      kp_sk[j] <= 65'(skew_term) * 65'(rot[1][j]);
      kp_cx[j] <= 65'(cx_s) * 65'(rot[2][j]);
      kp_fy[j] <= 65'(fy_s) * 65'(rot[1][j]);
      kp_cy[j] <= 65'(cy_s) * 65'(rot[2][j]);
      r2_k1[j] <= 50'((rot[2][j] + 33'sd8192) >>> 14);
    end
    kt_fx <= 64'(fx_s) * 64'(tr.trans_x);
    kt_sk <= 64'(skew_term) * 64'(tr.trans_y);
    kt_cx <= 64'(cx_s) * 64'(tr.trans_z);
    kt_fy <= 64'(fy_s) * 64'(tr.trans_y);
    kt_cy <= 64'(cy_s) * 64'(tr.trans_z);
    tz_k1 <= tr.trans_z;

    for (int j = 0; j < 3; j++) begin
      kr_fx[j] <= 50'((kp_fx[j] + 65'sd536870912) >>> 30);
      kr_sk[j] <= 50'((kp_sk[j] + 65'sd536870912) >>> 30);
      kr_cx[j] <= 50'((kp_cx[j] + 65'sd536870912) >>> 30);
      kr_fy[j] <= 50'((kp_fy[j] + 65'sd536870912) >>> 30);
      kr_cy[j] <= 50'((kp_cy[j] + 65'sd536870912) >>> 30);
    end
    kr_fx[3] <= 50'((kt_fx + 64'sd32768) >>> 16);
    kr_sk[3] <= 50'((kt_sk + 64'sd32768) >>> 16);
    kr_cx[3] <= 50'((kt_cx + 64'sd32768) >>> 16);
    kr_fy[3] <= 50'((kt_fy + 64'sd32768) >>> 16);
    kr_cy[3] <= 50'((kt_cy + 64'sd32768) >>> 16);
    r2_k2    <= r2_k1;
    tz_k2    <= tz_k1;

    for (int j = 0; j < 4; j++) begin
      row0[j] <= kr_fx[j] + kr_sk[j] + kr_cx[j];
      row1[j] <= kr_fy[j] + kr_cy[j];
    end
    r2_k3 <= r2_k2;
    tz_k3 <= tz_k2;

    mat0.row_index <= 2'd0;
    mat0.entry0    <= sat48(round_lvl(row0[0], lvl));
    mat0.entry1    <= sat48(round_lvl(row0[1], lvl));
    mat0.entry2    <= sat48(round_lvl(row0[2], lvl));
    mat0.entry3    <= sat48(round_lvl(row0[3], lvl));
    mat0.last_row  <= 1'b0;
    mat1.row_index <= 2'd1;
    mat1.entry0    <= sat48(round_lvl(row1[0], lvl));
    mat1.entry1    <= sat48(round_lvl(row1[1], lvl));
    mat1.entry2    <= sat48(round_lvl(row1[2], lvl));
    mat1.entry3    <= sat48(round_lvl(row1[3], lvl));
    mat1.last_row  <= 1'b0;
    mat2.row_index <= 2'd2;
    mat2.entry0    <= sat48(r2_k3[0]);
    mat2.entry1    <= sat48(r2_k3[1]);
    mat2.entry2    <= sat48(r2_k3[2]);
    mat2.entry3    <= sat48(50'(tz_k3));
    mat2.last_row  <= 1'b1;
  end

  // ---- output: row 0 at once, rows 1 and 2 from hold registers ----
  logic [1:0] pend;
  row_t       hold1, hold2;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_strobe <= 1'b0;
      pend       <= 2'd0;
    end else if (vld[PIPE_LAT-1]) begin
      row_strobe <= 1'b1;
      pend       <= 2'd2;
    end else if (pend != 2'd0) begin
      row_strobe <= 1'b1;
      pend       <= pend - 2'd1;
    end else begin
      row_strobe <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[PIPE_LAT-1]) begin
      row   <= mat0;
      hold1 <= mat1;
      hold2 <= mat2;
    end else if (pend == 2'd2) begin
      row <= hold1;
    end else if (pend == 2'd1) begin
      row <= hold2;
    end
  end

endmodule

// ----- rtl/core/eppm_checker.sv -----
// Port-level checks for the projection matrix unit, bound to the top level.
module eppm_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           row_strobe,
  input eppm_pkg::row_t row
);
  import eppm_pkg::*;

  // a taken pose must raise busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after an accepted pose");

  // rows of one matrix follow in consecutive cycles
  a_row0_then_row1: assert property (@(posedge clk) disable iff (rst)
    row_strobe && row.row_index == 2'd0 |=> row_strobe && row.row_index == 2'd1)
    else $error("row 1 did not follow row 0");

  a_row1_then_row2: assert property (@(posedge clk) disable iff (rst)
    row_strobe && row.row_index == 2'd1 |=> row_strobe && row.row_index == 2'd2
      && row.last_row)
    else $error("row 2 did not follow row 1");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    row_strobe |-> (row.last_row == (row.row_index == 2'd2)))
    else $error("last_row does not match row index");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !row_strobe && !busy)
    else $error("activity right after reset");

endmodule

bind euler_pose_projection_matrix_unit eppm_checker u_eppm_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .row_strobe (row_strobe),
  .row        (row)
);
